[rtl/fixed_block_pool_allocator_top_defines.svh]
// Assertion macros used by the checker file
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_TOP_DEFINES_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication, off while reset is high
`define FBPA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fbpa assertion failed");

// next-cycle implication, off while reset is high
`define FBPA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fbpa assertion failed");

// next-cycle implication, checked during reset too
`define FBPA_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("fbpa assertion failed");

`endif

[rtl/fbpa_pkg.sv]
package fbpa_pkg;

   localparam int CFG_W      = 13;
   localparam int REQ_W      = 16;
   localparam int BLK_IDX_W  = 8;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 1;

   localparam logic [CFG_W-1:0] MIN_REQUEST_RESET = 13'd1;
   localparam logic [CFG_W-1:0] BLOCK_BYTES_RESET = 13'd64;

   localparam logic [REG_IDX_W-1:0] REG_MIN_REQUEST_BYTES = 1'b0;
   localparam logic [REG_IDX_W-1:0] REG_BLOCK_BYTES       = 1'b1;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   typedef enum logic [2:0] {
      ST_ALLOC    = 3'd0,
      ST_BAD_SIZE = 3'd1,
      ST_EMPTY    = 3'd2,
      ST_FREED    = 3'd3,
      ST_IGNORED  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      STATE_INIT,
      STATE_RUN,
      STATE_POP
   } state_type;

   typedef struct packed {
      logic [CFG_W-1:0] min_request_bytes;
      logic [CFG_W-1:0] block_bytes;
   } cfg_type;

endpackage

[rtl/fixed_block_pool_allocator_top.sv]
// Channel   Direction  Handshake            Word
// req       in         req_valid/req_ready  kind, request_bytes, block_index, null_block
// rsp       out        rsp_valid/rsp_ready  status, granted_index
// csr       in/out     psel/penable/pready  min_request_bytes @0x0, block_bytes @0x4
//
// A successful allocate passes through the POP state: the link of the head block is read from the
// single-port link memory, whose read data is registered, before the head moves.
// Every other word is answered from the RUN state. One word is in flight at a time.
// After reset a clearing pass writes the initial chain, one link per block, with req_ready low.
// The result register decouples rsp; a new word is taken once it is empty or being taken.

module fixed_block_pool_allocator_top #(
   parameter int NUM_BLOCKS = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_kind,
   input  logic [15:0]                      req_request_bytes,
   input  logic [7:0]                       req_block_index,
   input  logic                             req_null_block,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [2:0]                       rsp_status,
   output logic [7:0]                       rsp_granted_index,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [fbpa_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [fbpa_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [fbpa_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready
);

   localparam int IDX_W  = $clog2(NUM_BLOCKS);
   localparam int LINK_W = IDX_W + 1;

   fbpa_pkg::cfg_type    cfg;
   fbpa_pkg::state_type  state_ff;
   fbpa_pkg::state_type  state_in;
   fbpa_pkg::status_type rsp_status_ff;
   fbpa_pkg::status_type rsp_status_in;

   logic [LINK_W-1:0] link_mem [NUM_BLOCKS];
   logic [LINK_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]  init_cnt_ff;
   logic [IDX_W-1:0]  init_cnt_in;
   logic [LINK_W-1:0] head_ff;
   logic [LINK_W-1:0] head_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [7:0]        rsp_granted_ff;
   logic [7:0]        rsp_granted_in;

   logic              mem_we;
   logic              mem_re;
   logic [IDX_W-1:0]  mem_waddr;
   logic [LINK_W-1:0] mem_wdata;
   logic              req_fire;
   logic              size_bad;
   logic              pool_empty;
   logic              idx_bad;
   logic [IDX_W-1:0]  free_idx;

   fbpa_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign req_ready  = (state_ff == fbpa_pkg::STATE_RUN) && (!rsp_valid_ff || rsp_ready);
   assign req_fire   = req_valid && req_ready;
   assign size_bad   = (req_request_bytes > {3'b0, cfg.block_bytes})
                    || (req_request_bytes < {3'b0, cfg.min_request_bytes});
   assign pool_empty = (head_ff >= LINK_W'(NUM_BLOCKS));
   assign idx_bad    = ({24'b0, req_block_index} >= 32'(NUM_BLOCKS));
   assign free_idx   = IDX_W'({{IDX_W{1'b0}}, req_block_index});

   always_comb begin
      state_in       = state_ff;
      init_cnt_in    = init_cnt_ff;
      head_in        = head_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_granted_in = rsp_granted_ff;
      mem_we         = 1'b0;
      mem_re         = 1'b0;
      mem_waddr      = init_cnt_ff;
      mem_wdata      = {1'b0, init_cnt_ff} + LINK_W'(1);
      case (state_ff)
         fbpa_pkg::STATE_INIT: begin
            mem_we = 1'b1;
            if (init_cnt_ff == IDX_W'(NUM_BLOCKS - 1)) begin
               state_in = fbpa_pkg::STATE_RUN;
            end else begin
               init_cnt_in = init_cnt_ff + IDX_W'(1);
            end
         end
         fbpa_pkg::STATE_RUN: begin
            if (req_fire) begin
               rsp_granted_in = '0;
               if (req_kind == fbpa_pkg::KIND_ALLOC) begin
                  if (size_bad) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = fbpa_pkg::ST_BAD_SIZE;
                  end else if (pool_empty) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = fbpa_pkg::ST_EMPTY;
                  end else begin
                     mem_re   = 1'b1;
                     state_in = fbpa_pkg::STATE_POP;
                  end
               end else if (req_null_block || idx_bad) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = fbpa_pkg::ST_IGNORED;
               end else begin
                  mem_we        = 1'b1;
                  mem_waddr     = free_idx;
                  mem_wdata     = head_ff;
                  head_in       = {1'b0, free_idx};
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = fbpa_pkg::ST_FREED;
               end
            end
         end
         fbpa_pkg::STATE_POP: begin
            head_in        = rd_data_ff;
            rsp_valid_in   = 1'b1;
            rsp_status_in  = fbpa_pkg::ST_ALLOC;
            rsp_granted_in = 8'({8'b0, head_ff});
            state_in       = fbpa_pkg::STATE_RUN;
         end
         default: begin
            state_in = fbpa_pkg::STATE_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         link_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= link_mem[head_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fbpa_pkg::STATE_INIT;
         init_cnt_ff  <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_cnt_ff  <= init_cnt_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff  <= rsp_status_in;
      rsp_granted_ff <= rsp_granted_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_granted_index = rsp_granted_ff;

endmodule

[rtl/fbpa_csr.sv]
module fbpa_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [fbpa_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [fbpa_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [fbpa_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready,
   output fbpa_pkg::cfg_type                cfg
);

   logic [fbpa_pkg::CFG_W-1:0]     min_request_ff;
   logic [fbpa_pkg::CFG_W-1:0]     min_request_in;
   logic [fbpa_pkg::CFG_W-1:0]     block_bytes_ff;
   logic [fbpa_pkg::CFG_W-1:0]     block_bytes_in;
   logic [fbpa_pkg::REG_IDX_W-1:0] reg_idx;
   logic                           wr_en;

   assign reg_idx = paddr[fbpa_pkg::CSR_ADDR_W-1:2];
   assign wr_en   = psel & penable & pwrite;
   assign pready  = 1'b1;

   always_comb begin
      min_request_in = min_request_ff;
      block_bytes_in = block_bytes_ff;
      prdata         = '0;
      case (reg_idx)
         fbpa_pkg::REG_MIN_REQUEST_BYTES: begin
            prdata = fbpa_pkg::CSR_DATA_W'(min_request_ff);
            if (wr_en) begin
               min_request_in = pwdata[fbpa_pkg::CFG_W-1:0];
            end
         end
         fbpa_pkg::REG_BLOCK_BYTES: begin
            prdata = fbpa_pkg::CSR_DATA_W'(block_bytes_ff);
            if (wr_en) begin
               block_bytes_in = pwdata[fbpa_pkg::CFG_W-1:0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_request_ff <= fbpa_pkg::MIN_REQUEST_RESET;
         block_bytes_ff <= fbpa_pkg::BLOCK_BYTES_RESET;
      end else begin
         min_request_ff <= min_request_in;
         block_bytes_ff <= block_bytes_in;
      end
   end

   assign cfg.min_request_bytes = min_request_ff;
   assign cfg.block_bytes       = block_bytes_ff;

endmodule

[rtl/fbpa_checker.sv]
`include "fixed_block_pool_allocator_top_defines.svh"

module fbpa_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_kind,
   input logic        req_null_block,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic [7:0]  rsp_granted_index
);

   logic null_free_fire;
   logic rsp_stalled;
   logic rsp_no_grant;
   logic rsp_ignored;

   assign null_free_fire = req_valid && req_ready
                        && (req_kind == fbpa_pkg::KIND_FREE) && req_null_block;
   assign rsp_stalled    = rsp_valid && !rsp_ready;
   assign rsp_no_grant   = rsp_valid && (rsp_status != fbpa_pkg::ST_ALLOC);
   assign rsp_ignored    = rsp_valid && (rsp_status == fbpa_pkg::ST_IGNORED);

   // hold a stalled result word
   `FBPA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stalled, rsp_valid)

   // drop no result: no word is taken while the result register stalls
   `FBPA_ASSERT_NOW(a_no_accept_on_stall, clock, reset, rsp_stalled, !req_ready)

   // a granted index only goes with an allocation
   `FBPA_ASSERT_NOW(a_grant_zero, clock, reset, rsp_no_grant, rsp_granted_index == 8'd0)

   // a null free answers in the next cycle
   `FBPA_ASSERT_NEXT(a_null_free, clock, reset, null_free_fire, rsp_ignored)

   // the clearing pass holds off requests after reset
   `FBPA_ASSERT_NEXT_ALWAYS(a_init_block, clock, reset, !req_ready)

endmodule

bind fixed_block_pool_allocator_top fbpa_checker u_fbpa_checker (.*);
